[src/tdp_pkg.sv]
// shared constants and types for the trial-division prime tester
package tdp_pkg;

  localparam int WIDTH     = 32;
  localparam int MAX_LIST  = 64;
  localparam int LIST_SPAN = 10;

  localparam int DIV_W  = 16;
  localparam int SQ_W   = WIDTH + 2;
  localparam int LIST_W = 10;
  localparam int CNT_W  = 7;
  localparam int STEP_W = $clog2(WIDTH + 1);

  localparam logic OP_TEST = 1'b0;
  localparam logic OP_LIST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_DIVIDE,
    ST_EMIT,
    ST_LIST_NEXT
  } state_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

[src/trial_division_prime_test.sv]
// top level: trial-division primality test and prime list generator
//
// input channel: in_valid / in_stall with opcode and number. opcode 0 tests
// number and gives one result (is_prime, prime_value 0, last 1). opcode 1
// lists the first number primes (clamped to 64) in ascending order with
// is_prime 1 and last on the final one; a count of zero or less gives none.
// output channel: out_valid / out_stall with is_prime, prime_value, last.
//
// one item is worked on at a time; in_stall is high until it is finished.
// each trial divisor runs through the bit-serial remainder unit; a test
// of n tries divisors from 2 while their square is at most n and stops
// at the first that divides, and n below 4 needs no division at all.
// a list of 64 primes scans candidates 0..311.
// results sit in an output register; the next item is taken while the
// last result waits, and work pauses only when a new result is ready and
// the register is still held by a stalled receiver.
// reset (rst, synchronous) returns to idle and drops out_valid.
module trial_division_prime_test
  import tdp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     opcode,
  input  logic signed [WIDTH-1:0]  number,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     is_prime,
  output logic [LIST_W-1:0]        prime_value,
  output logic                     last
);

  state_t            state, state_next;
  logic [WIDTH-1:0]  value, value_next;
  logic [DIV_W-1:0]  divisor, divisor_next;
  logic [SQ_W-1:0]   square, square_next;
  logic [LIST_W-1:0] cand, cand_next;
  logic [LIST_W-1:0] bound, bound_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  found, found_next;
  logic              list_mode, list_mode_next;
  logic              verdict, verdict_next;

  logic              rem_start;
  logic              load_out;
  logic              square_over;
  logic              out_last;
  logic [LIST_W:0]   cand_inc;
  logic [CNT_W-1:0]  found_inc;
  rem_status_t       rem_status;

  tdp_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (value),
    .divisor  (divisor),
    .status   (rem_status)
  );

  assign square_over = square > {2'b00, value};
  assign cand_inc    = {1'b0, cand} + (LIST_W + 1)'(1);
  assign found_inc   = found + CNT_W'(1);
  assign out_last    = list_mode ? (found_inc == count) : 1'b1;

  // control outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    rem_start = (state == ST_CHECK) && !square_over;
    load_out  = (state == ST_EMIT) && (!out_valid || !out_stall);
  end

  // next state and working registers
  always_comb begin
    state_next     = state;
    value_next     = value;
    divisor_next   = divisor;
    square_next    = square;
    cand_next      = cand;
    bound_next     = bound;
    count_next     = count;
    found_next     = found;
    list_mode_next = list_mode;
    verdict_next   = verdict;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_TEST) begin
            list_mode_next = 1'b0;
            value_next     = number;
            divisor_next   = DIV_W'(2);
            square_next    = SQ_W'(4);
            if (number[WIDTH-1] || number[WIDTH-1:1] == '0) begin
              verdict_next = 1'b0;
              state_next   = ST_EMIT;
            end else begin
              state_next = ST_CHECK;
            end
          end else if (!number[WIDTH-1] && number != '0) begin
            list_mode_next = 1'b1;
            if (number > WIDTH'(MAX_LIST)) begin
              count_next = CNT_W'(MAX_LIST);
            end else begin
              count_next = number[CNT_W-1:0];
            end
            bound_next = LIST_W'(count_next * LIST_SPAN);
            cand_next  = '0;
            found_next = '0;
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        value_next   = WIDTH'(cand);
        divisor_next = DIV_W'(2);
        square_next  = SQ_W'(4);
        if (cand < LIST_W'(2)) begin
          state_next = ST_LIST_NEXT;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (square_over) begin
          verdict_next = 1'b1;
          state_next   = ST_EMIT;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (rem_status.done) begin
          if (rem_status.zero) begin
            verdict_next = 1'b0;
            state_next   = list_mode ? ST_LIST_NEXT : ST_EMIT;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            square_next  = square + SQ_W'({divisor, 1'b1});
            divisor_next = divisor + DIV_W'(1);
            state_next   = ST_CHECK;
          end
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          if (list_mode) begin
            found_next = found_inc;
            state_next = out_last ? ST_IDLE : ST_LIST_NEXT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_LIST_NEXT: begin
        cand_next = cand_inc[LIST_W-1:0];
        if (cand_inc >= {1'b0, bound}) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_START;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    value     <= value_next;
    divisor   <= divisor_next;
    square    <= square_next;
    cand      <= cand_next;
    bound     <= bound_next;
    count     <= count_next;
    found     <= found_next;
    list_mode <= list_mode_next;
    verdict   <= verdict_next;
    if (load_out) begin
      is_prime    <= verdict;
      prime_value <= list_mode ? cand : '0;
      last        <= out_last;
    end
  end

endmodule

[src/tdp_rem.sv]
// bit-serial restoring remainder unit, one dividend bit per cycle
module tdp_rem
  import tdp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WIDTH-1:0]   dividend,
  input  logic [DIV_W-1:0]   divisor,
  output rem_status_t        status
);

  logic [WIDTH-1:0]  shreg;
  logic [DIV_W-1:0]  rem;
  logic [STEP_W-1:0] cnt;
  logic              active;
  logic              done;
  logic [DIV_W:0]    trial;

  assign trial = {rem, shreg[WIDTH-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && cnt == STEP_W'(1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      cnt   <= STEP_W'(WIDTH);
    end else if (active) begin
      shreg <= {shreg[WIDTH-2:0], 1'b0};
      cnt   <= cnt - STEP_W'(1);
      // keep the difference only when the divisor fits
      if (trial >= {1'b0, divisor}) begin
        rem <= DIV_W'(trial - {1'b0, divisor});
      end else begin
        rem <= DIV_W'(trial);
      end
    end
  end

  assign status.done = done;
  assign status.zero = (rem == '0);

endmodule
